/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an expression never becomes true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_PROP(lbl, !(expr), msg)

`endif

/* rtl/c2dvb_pkg.sv */
// ----------------------------------------------------------------------------
// c2dvb_pkg
// Widths, register codes and reset values of the 3x3 valid convolution core.
// ----------------------------------------------------------------------------
package c2dvb_pkg;

  localparam int PIX_W      = 16;
  localparam int PROD_W     = 32;
  localparam int ROWSUM_W   = 34;
  localparam int TOTAL_W    = 36;
  localparam int RES_W      = 32;
  localparam int CNT_W      = 8;
  localparam int DIM_W      = 9;
  localparam int KSEL_W     = 2;
  localparam int WIN        = 3;
  localparam int MAX_KERNEL = 3;
  localparam int MAX_DIM    = 256;
  localparam int WROW_W     = WIN * PIX_W;
  localparam int BIAS_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int OUT_DATA_W = RES_W + 2 * CNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_ROWS  = 3'd0,
    CFG_KERNEL_COLS  = 3'd1,
    CFG_IMAGE_HEIGHT = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_WEIGHTS_ROW0 = 3'd4,
    CFG_WEIGHTS_ROW1 = 3'd5,
    CFG_WEIGHTS_ROW2 = 3'd6,
    CFG_BIAS_VALUE   = 3'd7
  } cfg_reg_e;

  localparam logic [KSEL_W-1:0] RST_KERNEL_ROWS  = 2'd3;
  localparam logic [KSEL_W-1:0] RST_KERNEL_COLS  = 2'd3;
  localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 9'd5;
  localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 9'd5;

  typedef struct packed {
    logic             emit;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last;
  } meta_t;

endpackage

/* rtl/conv2d_valid_bias_core.sv */
// ----------------------------------------------------------------------------
// conv2d_valid_bias_core
// Streaming 3x3 valid-mode convolution with bias over Q8.8 raster images.
// ----------------------------------------------------------------------------
// The core takes one pixel word per cycle and returns a result word for every
// window that lies wholly inside the image, after the input, window, product,
// row-sum and output registers; pixels whose window does not fit give no word.
// The rate of one pixel per cycle is set by the line memory, which is read at
// the pixel's column when the pixel is taken and written back from stage 1,
// and by the nine parallel multipliers that follow; it holds as long as the
// output side takes its words. The line memory has no reset and needs no
// clearing pass: every entry a fitting window reads was written earlier in the
// same image. Write the configuration only while no pixel is in flight.
module conv2d_valid_bias_core #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] pixel
  input  logic [c2dvb_pkg::PIX_W-1:0]           s_axis_tdata,
  // [0] image_start
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [31:0] result_value, [39:32] out_row, [47:40] out_col
  output logic [c2dvb_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // image_last
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [c2dvb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [c2dvb_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WMAX   = (MAX_WIDTH < c2dvb_pkg::MAX_DIM) ? MAX_WIDTH : c2dvb_pkg::MAX_DIM;
  localparam int LINE_W = 2 * c2dvb_pkg::PIX_W;

  localparam logic [c2dvb_pkg::DIM_W-1:0] HMAX_V = c2dvb_pkg::DIM_W'(c2dvb_pkg::MAX_DIM);
  localparam logic [c2dvb_pkg::DIM_W-1:0] WMAX_V = c2dvb_pkg::DIM_W'(WMAX);
  localparam logic [c2dvb_pkg::KSEL_W-1:0] KMAX_V =
    c2dvb_pkg::KSEL_W'(c2dvb_pkg::MAX_KERNEL);

  // configuration registers
  logic [c2dvb_pkg::KSEL_W-1:0] kr_cfg_q, kc_cfg_q;
  logic [c2dvb_pkg::DIM_W-1:0]  h_cfg_q, w_cfg_q;
  logic [c2dvb_pkg::WROW_W-1:0] wgt_q [c2dvb_pkg::WIN];
  logic [c2dvb_pkg::BIAS_W-1:0] bias_q;

  logic [c2dvb_pkg::KSEL_W-1:0] kr, kc;
  logic [c2dvb_pkg::DIM_W-1:0]  h, w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kr_cfg_q <= c2dvb_pkg::RST_KERNEL_ROWS;
      kc_cfg_q <= c2dvb_pkg::RST_KERNEL_COLS;
      h_cfg_q  <= c2dvb_pkg::RST_IMAGE_HEIGHT;
      w_cfg_q  <= c2dvb_pkg::RST_IMAGE_WIDTH;
      for (int i = 0; i < c2dvb_pkg::WIN; i++) begin
        wgt_q[i] <= '0;
      end
      bias_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (c2dvb_pkg::cfg_reg_e'(cfg_index_i))
        c2dvb_pkg::CFG_KERNEL_ROWS:  kr_cfg_q <= cfg_data_i[c2dvb_pkg::KSEL_W-1:0];
        c2dvb_pkg::CFG_KERNEL_COLS:  kc_cfg_q <= cfg_data_i[c2dvb_pkg::KSEL_W-1:0];
        c2dvb_pkg::CFG_IMAGE_HEIGHT: h_cfg_q  <= cfg_data_i[c2dvb_pkg::DIM_W-1:0];
        c2dvb_pkg::CFG_IMAGE_WIDTH:  w_cfg_q  <= cfg_data_i[c2dvb_pkg::DIM_W-1:0];
        c2dvb_pkg::CFG_WEIGHTS_ROW0: wgt_q[0] <= cfg_data_i[c2dvb_pkg::WROW_W-1:0];
        c2dvb_pkg::CFG_WEIGHTS_ROW1: wgt_q[1] <= cfg_data_i[c2dvb_pkg::WROW_W-1:0];
        c2dvb_pkg::CFG_WEIGHTS_ROW2: wgt_q[2] <= cfg_data_i[c2dvb_pkg::WROW_W-1:0];
        c2dvb_pkg::CFG_BIAS_VALUE:   bias_q   <= cfg_data_i[c2dvb_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes into their legal ranges
  always_comb begin
    kr = (kr_cfg_q == '0) ? 2'd1 : ((kr_cfg_q > KMAX_V) ? KMAX_V : kr_cfg_q);
    kc = (kc_cfg_q == '0) ? 2'd1 : ((kc_cfg_q > KMAX_V) ? KMAX_V : kc_cfg_q);
    h  = (h_cfg_q == '0) ? 9'd1 : ((h_cfg_q > HMAX_V) ? HMAX_V : h_cfg_q);
    w  = (w_cfg_q == '0) ? 9'd1 : ((w_cfg_q > WMAX_V) ? WMAX_V : w_cfg_q);
  end

  // pipeline advance: stall everything only while the output word waits
  logic out_valid_q;
  logic adv, accept;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // stage 0: position counters and line memory read
  logic [c2dvb_pkg::CNT_W-1:0] row_q, col_q, row_d, col_d;
  logic [c2dvb_pkg::CNT_W-1:0] r0, c0;
  logic [c2dvb_pkg::DIM_W-1:0] r0x, c0x, r1x, c1x, krx, kcx;
  c2dvb_pkg::meta_t            meta0;
  logic [AW-1:0]               addr0;

  always_comb begin
    r0    = s_axis_tuser ? '0 : row_q;
    c0    = s_axis_tuser ? '0 : col_q;
    r0x   = {1'b0, r0};
    c0x   = {1'b0, c0};
    r1x   = r0x + 9'd1;
    c1x   = c0x + 9'd1;
    krx   = c2dvb_pkg::DIM_W'(kr);
    kcx   = c2dvb_pkg::DIM_W'(kc);
    addr0 = AW'(c0);
    meta0.emit = (r0x < h) && (c0x < w) && (r1x >= krx) && (c1x >= kcx);
    meta0.row  = c2dvb_pkg::CNT_W'(r1x - krx);
    meta0.col  = c2dvb_pkg::CNT_W'(c1x - kcx);
    meta0.last = (r1x == h) && (c1x == w);
    if (c1x >= w) begin
      col_d = '0;
      row_d = (r1x >= h) ? '0 : c2dvb_pkg::CNT_W'(r1x);
    end else begin
      col_d = c2dvb_pkg::CNT_W'(c1x);
      row_d = r0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // line memory: per column {two rows up, one row up}
  logic [LINE_W-1:0]           line_mem [MAX_WIDTH];
  logic [LINE_W-1:0]           rd_data_q, fwd_data_q, line1, wr_data1;
  logic                        fwd_q;
  logic                        s1_valid_q;
  c2dvb_pkg::meta_t            s1_meta_q;
  logic [c2dvb_pkg::PIX_W-1:0] s1_px_q;
  logic [AW-1:0]               s1_addr_q;
  logic                        wr_en1;

  assign line1    = fwd_q ? fwd_data_q : rd_data_q;
  assign wr_data1 = {line1[c2dvb_pkg::PIX_W-1:0], s1_px_q};
  assign wr_en1   = s1_valid_q && adv;

  always_ff @(posedge clk_i) begin
    if (wr_en1) begin
      line_mem[s1_addr_q] <= wr_data1;
    end
    if (accept) begin
      rd_data_q <= line_mem[addr0];
    end
  end

  // forward the write-back when the next pixel hits the same column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= s1_valid_q && (s1_addr_q == addr0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= wr_data1;
      s1_meta_q  <= meta0;
      s1_px_q    <= s_axis_tdata;
      s1_addr_q  <= addr0;
    end
  end

  // stage 1: shift the window
  logic signed [c2dvb_pkg::PIX_W-1:0] win_q [c2dvb_pkg::WIN][c2dvb_pkg::WIN];
  logic                               s2_valid_q;
  c2dvb_pkg::meta_t                   s2_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < c2dvb_pkg::WIN; i++) begin
        for (int j = 0; j < c2dvb_pkg::WIN; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (wr_en1) begin
      for (int i = 0; i < c2dvb_pkg::WIN; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= line1[LINE_W-1:c2dvb_pkg::PIX_W];
      win_q[1][2] <= line1[c2dvb_pkg::PIX_W-1:0];
      win_q[2][2] <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_meta_q <= s1_meta_q;
    end
  end

  // stage 2: products over the selected kernel
  logic signed [c2dvb_pkg::PROD_W-1:0] prod_d [c2dvb_pkg::WIN][c2dvb_pkg::WIN];
  logic signed [c2dvb_pkg::PROD_W-1:0] prod_q [c2dvb_pkg::WIN][c2dvb_pkg::WIN];
  logic                                s3_valid_q;
  c2dvb_pkg::meta_t                    s3_meta_q;

  always_comb begin
    logic [c2dvb_pkg::KSEL_W-1:0]       ri, cj;
    logic signed [c2dvb_pkg::PIX_W-1:0] px, wt;
    for (int i = 0; i < c2dvb_pkg::WIN; i++) begin
      for (int j = 0; j < c2dvb_pkg::WIN; j++) begin
        ri = c2dvb_pkg::KSEL_W'(3 - int'(kr) + i);
        cj = c2dvb_pkg::KSEL_W'(3 - int'(kc) + j);
        wt = wgt_q[i][j*c2dvb_pkg::PIX_W +: c2dvb_pkg::PIX_W];
        if ((i < int'(kr)) && (j < int'(kc))) begin
          px = win_q[ri][cj];
        end else begin
          px = '0;
        end
        prod_d[i][j] = px * wt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q    <= prod_d;
      s3_meta_q <= s2_meta_q;
    end
  end

  // stage 3: row sums
  logic signed [c2dvb_pkg::ROWSUM_W-1:0] rowsum_q [c2dvb_pkg::WIN];
  logic                                  s4_valid_q;
  c2dvb_pkg::meta_t                      s4_meta_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < c2dvb_pkg::WIN; i++) begin
        rowsum_q[i] <= c2dvb_pkg::ROWSUM_W'(prod_q[i][0])
                     + c2dvb_pkg::ROWSUM_W'(prod_q[i][1])
                     + c2dvb_pkg::ROWSUM_W'(prod_q[i][2]);
      end
      s4_meta_q <= s3_meta_q;
    end
  end

  // stage 4: add bias, saturate, hold in the output register
  logic signed [c2dvb_pkg::TOTAL_W-1:0] total;
  logic [c2dvb_pkg::RES_W-1:0]          sat;
  logic [c2dvb_pkg::OUT_DATA_W-1:0]     out_data_q;
  logic                                 out_last_q;

  always_comb begin
    total = c2dvb_pkg::TOTAL_W'(rowsum_q[0]) + c2dvb_pkg::TOTAL_W'(rowsum_q[1])
          + c2dvb_pkg::TOTAL_W'(rowsum_q[2])
          + c2dvb_pkg::TOTAL_W'($signed(bias_q));
    if (total[c2dvb_pkg::TOTAL_W-1:c2dvb_pkg::RES_W-1] == '0 ||
        total[c2dvb_pkg::TOTAL_W-1:c2dvb_pkg::RES_W-1] == '1) begin
      sat = total[c2dvb_pkg::RES_W-1:0];
    end else if (total[c2dvb_pkg::TOTAL_W-1]) begin
      sat = {1'b1, {(c2dvb_pkg::RES_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(c2dvb_pkg::RES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s4_valid_q) begin
      out_data_q <= {s4_meta_q.col, s4_meta_q.row, sat};
      out_last_q <= s4_meta_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= s_axis_tvalid;
      s2_valid_q  <= s1_valid_q && s1_meta_q.emit;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/c2dvb_checker.sv */
// ----------------------------------------------------------------------------
// c2dvb_checker
// Port-level checks of the convolution core, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c2dvb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [c2dvb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             cfg_ready_o
);

  `ASSERT_PROP(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")
  `ASSERT_PROP(a_in_ready, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input blocked without output stall")
  `ASSERT_PROP(a_in_free, m_axis_tready |-> s_axis_tready, "input blocked while output is taken")
  `ASSERT_NEVER(a_cfg_ready, !cfg_ready_o, "configuration port back-pressured")

endmodule

bind conv2d_valid_bias_core c2dvb_checker u_c2dvb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready_o   (cfg_ready_o)
);

/* verif/conv2d_valid_bias_core_tb.sv */
// ----------------------------------------------------------------------------
// conv2d_valid_bias_core_tb
// Self-checking bench for the streaming valid-mode 3x3 convolution core.
// ----------------------------------------------------------------------------
// A short table of directed pixels and register writes covers reset weights,
// saturation at both ends, zero-sized settings and an image that follows the
// previous one without a start flag. Random phases follow: each writes a new
// setting while the core is idle, then streams whole images with random
// pixels, stray start flags and cut-off images. A bit-accurate window model
// predicts every result word that the table does not give; both stream sides idle at random.
// ----------------------------------------------------------------------------
module conv2d_valid_bias_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int      RAND_ITEMS  = 950;
  localparam int      DRAIN_PAD   = 16;
  localparam int      STALL_LIMIT = 2000;
  localparam longint  SAT_MAX     = 64'sd2147483647;
  localparam longint  SAT_MIN     = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        last;
  } conv_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PIX_MODEL,
    ROW_PIX_NONE,
    ROW_PIX_GIVEN
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    c2dvb_pkg::cfg_reg_e idx;
    logic [47:0]         data;
    logic [15:0]         px;
    logic                start;
    conv_result_t        res;
  } dir_row_t;

  localparam conv_result_t NO_RES = '0;
  localparam int DIR_ROWS = 43;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_CFG, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_KERNEL_COLS, 48'd1, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_IMAGE_HEIGHT, 48'd0, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_IMAGE_WIDTH, 48'd2, 16'h0000, 1'b0, NO_RES},
    '{ROW_PIX_GIVEN, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h7FFF, 1'b1,
      '{32'h0, 8'd0, 8'd0, 1'b0}},
    '{ROW_PIX_GIVEN, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0,
      '{32'h0, 8'd0, 8'd1, 1'b1}},
    '{ROW_CFG, c2dvb_pkg::CFG_WEIGHTS_ROW0, 48'h0000_0000_0100, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_BIAS_VALUE, 48'h0000_7FFF_FFFF, 16'h0000, 1'b0, NO_RES},
    '{ROW_PIX_GIVEN, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h0001, 1'b1,
      '{32'h7FFF_FFFF, 8'd0, 8'd0, 1'b0}},
    '{ROW_PIX_MODEL, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_BIAS_VALUE, 48'h0000_8000_0000, 16'h0000, 1'b0, NO_RES},
    '{ROW_PIX_GIVEN, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b1,
      '{32'h8000_0000, 8'd0, 8'd0, 1'b0}},
    '{ROW_PIX_MODEL, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h7FFF, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd3, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_KERNEL_COLS, 48'd3, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_IMAGE_HEIGHT, 48'd3, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_IMAGE_WIDTH, 48'd3, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_WEIGHTS_ROW0, 48'h8000_8000_8000, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_WEIGHTS_ROW1, 48'h8000_8000_8000, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_WEIGHTS_ROW2, 48'h8000_8000_8000, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_BIAS_VALUE, 48'h0, 16'h0000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b1, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_GIVEN, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0,
      '{32'h7FFF_FFFF, 8'd0, 8'd0, 1'b1}},
    '{ROW_CFG, c2dvb_pkg::CFG_WEIGHTS_ROW0, 48'h7FFF_7FFF_7FFF, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_WEIGHTS_ROW1, 48'h7FFF_7FFF_7FFF, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_WEIGHTS_ROW2, 48'h7FFF_7FFF_7FFF, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG, c2dvb_pkg::CFG_BIAS_VALUE, 48'h0000_7FFF_FFFF, 16'h0000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_NONE, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0, NO_RES},
    '{ROW_PIX_GIVEN, c2dvb_pkg::CFG_KERNEL_ROWS, 48'd0, 16'h8000, 1'b0,
      '{32'h8000_0000, 8'd0, 8'd0, 1'b1}}
  };

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [c2dvb_pkg::PIX_W-1:0]      s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [c2dvb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;
  logic                             cfg_valid_i = 1'b0;
  logic                             cfg_ready_o;
  logic [c2dvb_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [c2dvb_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  conv2d_valid_bias_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Window model state and its copy of the registers.
  logic [1:0]   kr_reg = c2dvb_pkg::RST_KERNEL_ROWS;
  logic [1:0]   kc_reg = c2dvb_pkg::RST_KERNEL_COLS;
  logic [8:0]   h_reg = c2dvb_pkg::RST_IMAGE_HEIGHT;
  logic [8:0]   w_reg = c2dvb_pkg::RST_IMAGE_WIDTH;
  logic [47:0]  wt_reg [3] = '{default: '0};
  logic [31:0]  bias_reg = '0;
  logic [15:0]  line_mem [2][256] = '{default: '0};
  logic [15:0]  win_q [3][3] = '{default: '0};
  int unsigned  row_q = 0;
  int unsigned  col_q = 0;

  conv_result_t results_q [$];
  int           err_count = 0;
  int           idle_cycles = 0;
  bit           tx_quiet = 1'b0;
  bit           rx_quiet = 1'b0;
  int unsigned  rx_wait = 2;
  int unsigned  rx_stall;
  conv_result_t got;
  conv_result_t want;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_kernel(input logic [1:0] v);
    return (v == 2'd0) ? 32'd1 : 32'(v);
  endfunction

  function automatic int unsigned eff_dim(input logic [8:0] v);
    if (v == 9'd0) return 32'd1;
    if (v > 9'd256) return 32'd256;
    return 32'(v);
  endfunction

  function automatic logic [15:0] rand_pixel();
    logic [15:0] p;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: p = 16'h8000;
          1: p = 16'h7FFF;
          2: p = 16'h0000;
          default: p = 16'hFFFF;
        endcase
      end
      1, 2: p = 16'(int'($urandom_range(0, 2048)) - 1024);
      default: p = 16'($urandom);
    endcase
    return p;
  endfunction

  function automatic logic [47:0] rand_weights();
    logic [47:0] w;
    int unsigned lane;
    w = 48'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: w = {3{($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF}};
      1, 2: begin
        for (lane = 0; lane < 3; lane++) begin
          w[16*lane +: 16] = 16'(int'($urandom_range(0, 1024)) - 512);
        end
      end
      3: w = '0;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rand_bias();
    logic [31:0] b;
    case ($urandom_range(0, 5))
      0: b = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2: b = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: b = $urandom;
    endcase
    return b;
  endfunction

  // Fill unused upper bits of a register word now and then.
  function automatic logic [47:0] with_junk(input logic [47:0] v, input int w);
    logic [47:0] junk;
    junk = 48'({$urandom, $urandom});
    if ($urandom_range(0, 3) != 0) junk = '0;
    return (junk << w) | v;
  endfunction

  task automatic predict_pixel(input logic [15:0] px, input logic start,
                               output logic emit, output conv_result_t res);
    int unsigned kr, kc, hh, ww, r, c, i, j;
    logic [15:0] up2, up1;
    longint acc;
    kr = eff_kernel(kr_reg);
    kc = eff_kernel(kc_reg);
    hh = eff_dim(h_reg);
    ww = eff_dim(w_reg);
    if (start) begin
      row_q = 0;
      col_q = 0;
    end
    r = row_q;
    c = col_q;
    up2 = '0;
    up1 = '0;
    if (c < 256) begin
      up2 = line_mem[1][c];
      up1 = line_mem[0][c];
      line_mem[1][c] = up1;
      line_mem[0][c] = px;
    end
    for (i = 0; i < 3; i++) begin
      win_q[i][0] = win_q[i][1];
      win_q[i][1] = win_q[i][2];
    end
    win_q[0][2] = up2;
    win_q[1][2] = up1;
    win_q[2][2] = px;
    emit = 1'b0;
    res = '0;
    if (r < hh && c < ww && r + 1 >= kr && c + 1 >= kc) begin
      acc = longint'($signed(bias_reg));
      for (i = 0; i < kr; i++) begin
        for (j = 0; j < kc; j++) begin
          acc += longint'($signed(win_q[3-kr+i][3-kc+j])) *
                 longint'($signed(wt_reg[i][16*j +: 16]));
        end
      end
      if (acc > SAT_MAX) acc = SAT_MAX;
      if (acc < SAT_MIN) acc = SAT_MIN;
      res.value = acc[31:0];
      res.row = 8'(r + 1 - kr);
      res.col = 8'(c + 1 - kc);
      res.last = (r + 1 == hh && c + 1 == ww);
      emit = 1'b1;
    end
    if (c + 1 >= ww) begin
      col_q = 0;
      row_q = (r + 1 >= hh) ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
  endtask

  task automatic write_reg(input c2dvb_pkg::cfg_reg_e idx, input logic [47:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      c2dvb_pkg::CFG_KERNEL_ROWS:  kr_reg = data[1:0];
      c2dvb_pkg::CFG_KERNEL_COLS:  kc_reg = data[1:0];
      c2dvb_pkg::CFG_IMAGE_HEIGHT: h_reg = data[8:0];
      c2dvb_pkg::CFG_IMAGE_WIDTH:  w_reg = data[8:0];
      c2dvb_pkg::CFG_WEIGHTS_ROW0: wt_reg[0] = data;
      c2dvb_pkg::CFG_WEIGHTS_ROW1: wt_reg[1] = data;
      c2dvb_pkg::CFG_WEIGHTS_ROW2: wt_reg[2] = data;
      c2dvb_pkg::CFG_BIAS_VALUE:   bias_reg = data[31:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [15:0] px, input logic start,
                            output logic emit, output conv_result_t res);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= start;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predict_pixel(px, start, emit, res);
  endtask

  // Hold the input side until every pending word is out and the pipe is empty.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got.value = m_axis_tdata[31:0];
      got.row = m_axis_tdata[39:32];
      got.col = m_axis_tdata[47:40];
      got.last = m_axis_tlast;
      if (results_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("unexpected word: value %h row %0d col %0d last %0b",
                   got.value, got.row, got.col, got.last);
        end
      end else begin
        want = results_q.pop_front();
        if (got.value !== want.value || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch: expected value %h row %0d col %0d last %0b", want.value,
                     want.row, want.col, want.last);
            $display("          actual   value %h row %0d col %0d last %0b", got.value,
                     got.row, got.col, got.last);
          end
        end
      end
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
      rx_stall = rx_quiet ? 0 : $urandom_range(0, 9);
      if (rx_stall == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_wait <= rx_stall - 1;
      end
    end else if (!m_axis_tready) begin
      if (rx_wait == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        rx_wait <= rx_wait - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t     drow;
    bit           cfg_open;
    logic         emit;
    logic         start;
    conv_result_t res;
    int           rand_items;
    int           phase;
    int unsigned  n_img, img, k, cut_len, img_size;
    bit           cut, force_start;
    logic [1:0]   kr, kc;
    logic [8:0]   hh, ww;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_open = 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      drow = DIRECTED[i];
      if (drow.kind == ROW_CFG) begin
        if (!cfg_open) drain_results();
        write_reg(drow.idx, drow.data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid_i <= 1'b0;
        cfg_open = 1'b0;
        send_pixel(drow.px, drow.start, emit, res);
        if (drow.kind == ROW_PIX_GIVEN) begin
          results_q.push_back(drow.res);
        end else if (drow.kind == ROW_PIX_MODEL && emit) begin
          results_q.push_back(res);
        end
      end
    end

    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      drain_results();
      kr = 2'($urandom_range(0, 3));
      kc = 2'($urandom_range(0, 3));
      hh = 9'($urandom_range(1, 7));
      ww = 9'($urandom_range(1, 7));
      n_img = $urandom_range(1, 4);
      if (phase == 0) begin
        kr = 2'd1;
        hh = 9'd1;
        ww = 9'h1FF;
        n_img = 1;
      end else if (phase == 1) begin
        kc = 2'd1;
        hh = 9'd256;
        ww = 9'd1;
        n_img = 1;
      end else begin
        case ($urandom_range(0, 31))
          0: hh = 9'd0;
          1: ww = 9'd0;
          2: begin
            hh = 9'($urandom_range(200, 511));
            ww = 9'($urandom_range(1, 2));
            n_img = 1;
          end
          3: begin
            ww = 9'($urandom_range(200, 511));
            hh = 9'($urandom_range(1, 2));
            n_img = 1;
          end
          default: ;
        endcase
      end
      write_reg(c2dvb_pkg::CFG_KERNEL_ROWS, with_junk(48'(kr), 2));
      write_reg(c2dvb_pkg::CFG_KERNEL_COLS, with_junk(48'(kc), 2));
      write_reg(c2dvb_pkg::CFG_IMAGE_HEIGHT, with_junk(48'(hh), 9));
      write_reg(c2dvb_pkg::CFG_IMAGE_WIDTH, with_junk(48'(ww), 9));
      for (k = 0; k < 3; k++) begin
        if ($urandom_range(0, 1) != 0) begin
          write_reg(c2dvb_pkg::cfg_reg_e'(c2dvb_pkg::CFG_WEIGHTS_ROW0 + k), rand_weights());
        end
      end
      if ($urandom_range(0, 1) != 0) begin
        write_reg(c2dvb_pkg::CFG_BIAS_VALUE, with_junk(48'(rand_bias()), 32));
      end
      cfg_valid_i <= 1'b0;

      img_size = eff_dim(h_reg) * eff_dim(w_reg);
      force_start = 1'b0;
      for (img = 0; img < n_img; img++) begin
        cut = (img + 1 < n_img) && (img_size > 1) && ($urandom_range(0, 7) == 0);
        cut_len = cut ? $urandom_range(1, img_size - 1) : 0;
        k = 0;
        do begin
          if (k == 0) start = force_start || ($urandom_range(0, 3) != 0);
          else start = ($urandom_range(0, 49) == 0);
          send_pixel(rand_pixel(), start, emit, res);
          if (emit) results_q.push_back(res);
          k++;
          rand_items++;
        end while (cut ? (k < cut_len) : !(row_q == 0 && col_q == 0));
        force_start = cut;
      end
      phase++;
    end

    drain_results();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* conv2d_valid_bias_core.f */
+incdir+rtl
rtl/c2dvb_pkg.sv
rtl/conv2d_valid_bias_core.sv
rtl/c2dvb_checker.sv
verif/conv2d_valid_bias_core_tb.sv
